### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TER_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define TER_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define TER_ASSERT(label, clk, rstn, prop)
`define TER_NEVER(label, clk, rstn, expr)
`endif
`endif

### rtl/ter_pkg.sv
// ----------------------------------------------------------------------------
// ter_pkg
// shared types and constants of the tucker entry residual unit
// ----------------------------------------------------------------------------
package ter_pkg;

  localparam int DefMaxOrder = 4;
  localparam int DefMaxRows  = 1024;
  localparam int DefMaxRank  = 4;
  localparam int CoreDepth   = 256;
  localparam int NumIdx      = 4;
  localparam int FaMaxW      = 23;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_RANK  = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD_FACTOR = 2'd0,
    OP_LOAD_CORE   = 2'd1,
    OP_QUERY       = 2'd2,
    OP_CLEAR       = 2'd3
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic                        fac_ok;
    logic [FaMaxW-1:0]           fac_addr;
    logic [7:0]                  core_addr;
    logic [NumIdx-1:0][9:0]      idx;
    logic signed [31:0]          value;
  } item_t;

  typedef struct packed {
    logic [2:0] order;
    logic [2:0] rank;
  } cfg_t;

endpackage

### rtl/ter_front.sv
// ----------------------------------------------------------------------------
// ter_front
// classifies incoming beats and computes the factor store address of a load
// ----------------------------------------------------------------------------
module ter_front import ter_pkg::*; #(
  parameter int MAX_ORDER = DefMaxOrder,
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_RANK  = DefMaxRank
) (
  input  logic        [1:0]  op_i,
  input  logic        [1:0]  mode_i,
  input  logic        [9:0]  row_i,
  input  logic        [1:0]  col_i,
  input  logic        [7:0]  core_addr_i,
  input  logic        [9:0]  idx0_i,
  input  logic        [9:0]  idx1_i,
  input  logic        [9:0]  idx2_i,
  input  logic        [9:0]  idx3_i,
  input  logic signed [31:0] value_i,
  output item_t              item_o
);

  int addr;
  logic ok;

  always_comb begin
    ok   = (int'(mode_i) < MAX_ORDER) && (int'(row_i) < MAX_ROWS) && (int'(col_i) < MAX_RANK);
    addr = (int'(mode_i) * MAX_ROWS + int'(row_i)) * MAX_RANK + int'(col_i);
    item_o.op        = op_e'(op_i);
    item_o.fac_ok    = ok && (op_e'(op_i) == OP_LOAD_FACTOR);
    item_o.fac_addr  = ok ? FaMaxW'(addr) : '0;
    item_o.core_addr = core_addr_i;
    item_o.idx       = {idx3_i, idx2_i, idx1_i, idx0_i};
    item_o.value     = value_i;
  end

endmodule

### rtl/ter_queue.sv
// ----------------------------------------------------------------------------
// ter_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module ter_queue import ter_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### rtl/ter_back.sv
// ----------------------------------------------------------------------------
// ter_back
// stores, core walk sequencer, shared multiplier and error accumulation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ter_back import ter_pkg::*; #(
  parameter int MAX_ORDER = DefMaxOrder,
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_RANK  = DefMaxRank
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_residual_o,
  output logic        [62:0] out_sq_error_sum_o
);

  localparam int FDepth = MAX_ORDER * MAX_ROWS * MAX_RANK;
  localparam int FaW    = $clog2(FDepth);
  localparam int DigW   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RankW  = $clog2(MAX_RANK + 1);
  localparam int OrdLim = (MAX_ORDER < NumIdx) ? MAX_ORDER : NumIdx;
  localparam logic [62:0] ErrMax = {63{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADC = 3'd1;
  localparam logic [2:0] S_TERM0 = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SAT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_SQ    = 3'd6;
  localparam logic [2:0] S_ADD   = 3'd7;

  logic [31:0] fmem [FDepth];
  logic [31:0] cmem [CoreDepth];
  logic [31:0] frd_q, crd_q;
  logic        fzero_q;

  logic [2:0]                     state_q, state_d;
  logic [2:0]                     ord_q, ord_d;
  logic [RankW-1:0]               rank_q, rank_d;
  logic [8:0]                     count_q, count_d, pos_q, pos_d;
  logic [1:0]                     m_q, m_d;
  logic [NumIdx-1:0][DigW-1:0]    dig_q, dig_d, dig_nx;
  logic [NumIdx-1:0][9:0]         idx_q, idx_d;
  logic signed [31:0]             val_q, val_d;
  logic signed [31:0]             term_q, term_d;
  logic signed [63:0]             prod_q, prod_d;
  logic signed [40:0]             acc_q, acc_d;
  logic signed [31:0]             res_q, res_d;
  logic        [62:0]             err_q, err_d;
  logic                           ov_q, ov_d;
  logic signed [31:0]             ores_q, ores_d;
  logic        [62:0]             osum_q, osum_d;

  logic           fwe, fre, cwe, cre;
  logic [FaW-1:0] fraddr;
  logic           fok;
  logic [2:0]     msel;
  logic           pop;

  logic [2:0]  ord_c;
  logic [RankW-1:0] rank_c;
  logic [12:0] cnt_c;
  logic signed [63:0] sh;
  logic signed [31:0] tsat, fval;
  logic signed [41:0] diff;
  logic [63:0] esum;
  int  faddr;
  logic carry;

  // clamped config and core walk length
  always_comb begin
    ord_c  = (cfg_i.order < 3'd1) ? 3'd1 :
             ((int'(cfg_i.order) > OrdLim) ? 3'(OrdLim) : cfg_i.order);
    rank_c = (cfg_i.rank < 3'd1) ? RankW'(1) :
             ((int'(cfg_i.rank) > MAX_RANK) ? RankW'(MAX_RANK) : RankW'(cfg_i.rank));
    cnt_c  = 13'd1;
    for (int k = 0; k < NumIdx; k++) begin
      if (k < int'(ord_c)) begin
        cnt_c = 13'(cnt_c * 13'(rank_c));
        if (cnt_c > 13'(CoreDepth)) cnt_c = 13'(CoreDepth);
      end
    end
  end

  // mixed radix advance, last mode fastest
  always_comb begin
    dig_nx = dig_q;
    carry  = 1'b1;
    for (int k = NumIdx - 1; k >= 0; k--) begin
      if (k < int'(ord_q) && carry) begin
        if (int'(dig_q[k]) + 1 < int'(rank_q)) begin
          dig_nx[k] = dig_q[k] + 1'b1;
          carry     = 1'b0;
        end else begin
          dig_nx[k] = '0;
        end
      end
    end
  end

  always_comb begin
    fok    = (int'(idx_q[msel[1:0]]) < MAX_ROWS);
    faddr  = (int'(msel) * MAX_ROWS + int'(idx_q[msel[1:0]])) * MAX_RANK
             + int'(dig_q[msel[1:0]]);
    fraddr = pop ? q_item_i.fac_addr[FaW-1:0] : (fok ? FaW'(faddr) : '0);
    sh     = prod_q >>> 16;
    tsat   = (sh > 64'sd2147483647) ? 32'sh7fffffff :
             ((sh < -64'sd2147483648) ? 32'sh80000000 : sh[31:0]);
    fval   = fzero_q ? 32'sd0 : frd_q;
    diff   = 42'(val_q) - 42'(acc_q);
    esum   = {1'b0, err_q} + {1'b0, prod_q[62:0]};
  end

  always_comb begin
    state_d = state_q;
    ord_d = ord_q; rank_d = rank_q; count_d = count_q; pos_d = pos_q;
    m_d = m_q; dig_d = dig_q; idx_d = idx_q; val_d = val_q;
    term_d = term_q; prod_d = prod_q; acc_d = acc_q; res_d = res_q;
    err_d = err_q;
    ov_d = ov_q && out_stall_i; ores_d = ores_q; osum_d = osum_q;
    pop = 1'b0; fwe = 1'b0; fre = 1'b0; cwe = 1'b0; cre = 1'b0;
    msel = 3'd0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          case (q_item_i.op)
            OP_LOAD_FACTOR: fwe = q_item_i.fac_ok;
            OP_LOAD_CORE:   cwe = 1'b1;
            OP_CLEAR:       err_d = '0;
            OP_QUERY: begin
              ord_d   = ord_c;
              rank_d  = rank_c;
              count_d = cnt_c[8:0];
              pos_d   = '0;
              dig_d   = '0;
              idx_d   = q_item_i.idx;
              val_d   = q_item_i.value;
              acc_d   = '0;
              state_d = S_LOADC;
            end
            default: ;
          endcase
        end
      end
      S_LOADC: begin
        cre = 1'b1; fre = 1'b1; msel = 3'd0; m_d = 2'd0;
        state_d = S_TERM0;
      end
      S_TERM0: begin
        term_d  = crd_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = 64'(term_q) * 64'(fval);
        state_d = S_SAT;
      end
      S_SAT: begin
        term_d = tsat;
        msel   = 3'(m_q) + 3'd1;
        if (msel < ord_q) begin
          fre = 1'b1; m_d = msel[1:0]; state_d = S_MUL;
        end else begin
          acc_d = acc_q + 41'(tsat);
          dig_d = dig_nx;
          pos_d = pos_q + 9'd1;
          state_d = (pos_q + 9'd1 == count_q) ? S_FIN : S_LOADC;
        end
      end
      S_FIN: begin
        res_d = (diff > 42'sd2147483647) ? 32'sh7fffffff :
                ((diff < -42'sd2147483648) ? 32'sh80000000 : diff[31:0]);
        state_d = S_SQ;
      end
      S_SQ: begin
        prod_d  = 64'(res_q) * 64'(res_q);
        state_d = S_ADD;
      end
      S_ADD: begin
        if (!ov_q || !out_stall_i) begin
          err_d   = esum[63] ? ErrMax : esum[62:0];
          ov_d    = 1'b1;
          ores_d  = res_q;
          osum_d  = esum[63] ? ErrMax : esum[62:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= '0;
      ov_q    <= 1'b0;
      pos_q   <= '0;
      m_q     <= '0;
      count_q <= 9'd1;
      ord_q   <= 3'd1;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
      pos_q   <= pos_d;
      m_q     <= m_d;
      count_q <= count_d;
      ord_q   <= ord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    dig_q  <= dig_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    term_q <= term_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    ores_q <= ores_d;
    osum_q <= osum_d;
  end

  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fraddr] <= q_item_i.value;
    if (fre) begin
      frd_q   <= fmem[fraddr];
      fzero_q <= !fok;
    end
    if (cwe) cmem[q_item_i.core_addr] <= q_item_i.value;
    if (cre) crd_q <= cmem[pos_q[7:0]];
  end

  assign q_pop_o            = pop;
  assign out_valid_o        = ov_q;
  assign out_residual_o     = ores_q;
  assign out_sq_error_sum_o = osum_q;

  `TER_ASSERT(a_pos_in_range, clk_i, rst_ni, (state_q == S_LOADC) |-> (pos_q < count_q))
  `TER_ASSERT(a_mode_in_range, clk_i, rst_ni, (state_q == S_MUL) |-> (3'(m_q) < ord_q))
  `TER_ASSERT(a_out_from_add, clk_i, rst_ni, $rose(ov_q) |-> ($past(state_q) == S_ADD))
  `TER_NEVER(a_pop_busy, clk_i, rst_ni, pop && (state_q != S_IDLE))

endmodule

### rtl/tucker_entry_residual_unit.sv
// ----------------------------------------------------------------------------
// tucker_entry_residual_unit
// residual of one observed sparse entry against a tucker model
// ----------------------------------------------------------------------------
// Factor and core words are loaded one beat each; a query reconstructs the
// entry from all core entries and returns the saturated Q16.16 residual with
// the running unsigned Q31.32 sum of squared residuals. Loads and clears are
// taken by the back end in its idle state. A query walks N = min(rank^order,
// 256) core entries in turn, its length set by the single shared 32x32
// multiplier and the single read port of the factor store. A two entry queue
// lets the front take beats while a query runs.
// ----------------------------------------------------------------------------
module tucker_entry_residual_unit import ter_pkg::*; #(
  parameter int MAX_ORDER = DefMaxOrder,
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_RANK  = DefMaxRank
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [2:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [1:0]  in_op_i,
  input  logic        [1:0]  in_mode_i,
  input  logic        [9:0]  in_row_i,
  input  logic        [1:0]  in_col_i,
  input  logic        [7:0]  in_core_addr_i,
  input  logic        [9:0]  in_idx0_i,
  input  logic        [9:0]  in_idx1_i,
  input  logic        [9:0]  in_idx2_i,
  input  logic        [9:0]  in_idx3_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_residual_o,
  output logic        [62:0] out_sq_error_sum_o
);

  cfg_t  cfg_q;
  item_t fr_item, q_item;
  logic  q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.order <= 3'd3;
      cfg_q.rank  <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORDER: cfg_q.order <= cfg_data_i;
        CFG_RANK:  cfg_q.rank  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ter_front #(
    .MAX_ORDER(MAX_ORDER), .MAX_ROWS(MAX_ROWS), .MAX_RANK(MAX_RANK)
  ) u_front (
    .op_i(in_op_i), .mode_i(in_mode_i), .row_i(in_row_i), .col_i(in_col_i),
    .core_addr_i(in_core_addr_i), .idx0_i(in_idx0_i), .idx1_i(in_idx1_i),
    .idx2_i(in_idx2_i), .idx3_i(in_idx3_i), .value_i(in_value_i),
    .item_o(fr_item)
  );

  ter_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(in_valid_i && !q_full), .item_i(fr_item), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .item_o(q_item)
  );

  ter_back #(
    .MAX_ORDER(MAX_ORDER), .MAX_ROWS(MAX_ROWS), .MAX_RANK(MAX_RANK)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_residual_o(out_residual_o), .out_sq_error_sum_o(out_sq_error_sum_o)
  );

endmodule
